[rtl/led_breathing_effect_macros.svh]
// ----------------------------------------------------------------------------
// LED breathing effect - assertion macros
// Shared concurrent assertion forms used by the block's controller.
// ----------------------------------------------------------------------------
`ifndef LED_BREATHING_EFFECT_MACROS_SVH
`define LED_BREATHING_EFFECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("led breathing effect: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("led breathing effect: assertion failed");

`endif

[rtl/lbe_pkg.sv]
// ----------------------------------------------------------------------------
// LED breathing effect - package
// Payload structures, controller/datapath signal groups and fixed constants.
// ----------------------------------------------------------------------------
package lbe_pkg;

  localparam logic [6:0] MAX_PIXELS = 7'd64;
  localparam logic [2:0] NUM_COLORS = 3'd4;

  localparam logic [15:0] RAMP_MS_RST = 16'd1500;
  localparam logic [15:0] HOLD_MS_RST = 16'd2000;
  localparam logic [7:0]  FULL_BRIGHT = 8'd255;

  // Phase codes
  localparam logic [1:0] PH_UP   = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_DOWN = 2'd2;
  localparam logic [1:0] PH_LOW  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_RAMP_MS     = 3'd0;
  localparam logic [2:0] REG_HOLD_MS     = 3'd1;
  localparam logic [2:0] REG_COLOR_COUNT = 3'd2;
  localparam logic [2:0] REG_COLOR_0     = 3'd3;
  localparam logic [2:0] REG_COLOR_1     = 3'd4;
  localparam logic [2:0] REG_COLOR_2     = 3'd5;
  localparam logic [2:0] REG_COLOR_3     = 3'd6;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [6:0]  pixel_count;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic init;
    logic phase_eval;
    logic div_load;
    logic div_step;
    logic mul;
    logic scale;
    logic emit_load;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic cnt_zero;
    logic pix_last;
  } sts_t;

endpackage

[rtl/lbe_ctrl.sv]
// ----------------------------------------------------------------------------
// LED breathing effect - controller
// Sequences one frame request through phase update, division, scaling and
// pixel output.
// ----------------------------------------------------------------------------
`include "led_breathing_effect_macros.svh"

module lbe_ctrl
  import lbe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_PHASE = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_SCALE = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_PHASE;
      end
      S_PHASE: begin
        cmd.phase_eval = 1'b1;
        state_nxt      = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale     = 1'b1;
        cmd.emit_load = 1'b1;
        state_nxt     = sts.cnt_zero ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (sts.pix_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LBE_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_r == S_INIT)
  `LBE_ASSERT_NEXT(a_div_ends, clk, rst_n, (state_r == S_DIV) && sts.div_last, state_r == S_MUL)
  `LBE_ASSERT_NEXT(a_scale_emits, clk, rst_n, (state_r == S_SCALE) && !sts.cnt_zero, out_valid)
  `LBE_ASSERT_NEXT(a_last_frees, clk, rst_n, out_valid && out_ready && sts.pix_last, in_ready)

endmodule

[rtl/lbe_dpath.sv]
// ----------------------------------------------------------------------------
// LED breathing effect - datapath
// Configuration registers, phase state, bit-serial ramp divider, channel
// scaling and the output pixel register.
// ----------------------------------------------------------------------------
module lbe_dpath
  import lbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  in_item_t    in_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output out_item_t   out_data
);

  // Exact floor(x / 255) for x up to 255 * 255, the largest channel product.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return sum[15:8];
  endfunction

  logic [15:0] ramp_ms_r;
  logic [15:0] hold_ms_r;
  logic [2:0]  color_count_r;
  logic [23:0] palette_r [0:3];

  logic        started_r, started_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] pstart_r, pstart_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [1:0]  pidx_r, pidx_nxt;

  logic [31:0] now_r;
  logic [6:0]  count_r;
  logic [15:0] delta_r, delta_nxt;
  logic [23:0] rem_r;
  logic [22:0] den_r;
  logic [7:0]  quo_r;
  logic [2:0]  step_r;
  logic [15:0] prod_r [0:2];
  logic [7:0]  rgb_r [0:2];
  logic [5:0]  pix_r;

  logic [31:0] delta_full;
  logic        overrun;
  logic [1:0]  ph_inc;
  logic [2:0]  cnt_lim;
  logic [2:0]  idx_inc;
  logic [1:0]  idx_wrap;
  logic [24:0] trial;
  logic [7:0]  ramp;
  logic [7:0]  bright;
  logic [23:0] col;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_ms_r     <= RAMP_MS_RST;
      hold_ms_r     <= HOLD_MS_RST;
      color_count_r <= 3'd4;
      palette_r[0]  <= 24'hFF0000;
      palette_r[1]  <= 24'h00FF00;
      palette_r[2]  <= 24'h0000FF;
      palette_r[3]  <= 24'hFFFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAMP_MS:     ramp_ms_r     <= cfg_data[15:0];
        REG_HOLD_MS:     hold_ms_r     <= cfg_data[15:0];
        REG_COLOR_COUNT: color_count_r <= cfg_data[2:0];
        REG_COLOR_0:     palette_r[0]  <= cfg_data;
        REG_COLOR_1:     palette_r[1]  <= cfg_data;
        REG_COLOR_2:     palette_r[2]  <= cfg_data;
        REG_COLOR_3:     palette_r[3]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Phase bookkeeping
  assign delta_full = now_r - pstart_r;
  assign overrun    = delta_full > {16'd0, plen_r};
  assign ph_inc     = phase_r + 2'd1;
  assign cnt_lim    = ((color_count_r == 3'd0) || (color_count_r > NUM_COLORS)) ?
                      NUM_COLORS : color_count_r;
  assign idx_inc    = {1'b0, pidx_r} + 3'd1;
  assign idx_wrap   = (idx_inc >= cnt_lim) ? 2'd0 : idx_inc[1:0];

  always_comb begin
    started_nxt = started_r;
    phase_nxt   = phase_r;
    pstart_nxt  = pstart_r;
    plen_nxt    = plen_r;
    pidx_nxt    = pidx_r;
    delta_nxt   = delta_r;
    if (cmd.init && !started_r) begin
      started_nxt = 1'b1;
      phase_nxt   = PH_UP;
      pstart_nxt  = now_r;
      plen_nxt    = ramp_ms_r;
    end
    if (cmd.phase_eval) begin
      if (overrun) begin
        pstart_nxt = pstart_r + {16'd0, plen_r};
        phase_nxt  = ph_inc;
        plen_nxt   = ((ph_inc == PH_HIGH) || (ph_inc == PH_LOW)) ? hold_ms_r : ramp_ms_r;
        if (ph_inc == PH_UP) begin
          pidx_nxt = idx_wrap;
        end
        delta_nxt = 16'd0;
      end else begin
        delta_nxt = delta_full[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      phase_r   <= PH_UP;
      pstart_r  <= 32'd0;
      plen_r    <= RAMP_MS_RST;
      pidx_r    <= 2'd0;
    end else begin
      started_r <= started_nxt;
      phase_r   <= phase_nxt;
      pstart_r  <= pstart_nxt;
      plen_r    <= plen_nxt;
      pidx_r    <= pidx_nxt;
    end
  end

  // Restoring divider: 255 * delta / length, one quotient bit per cycle.
  // The elapsed time never exceeds the length, so eight bits suffice.
  assign trial = {1'b0, rem_r} - {2'b00, den_r};

  // Brightness and palette selection
  assign ramp = (plen_r == 16'd0) ? FULL_BRIGHT : quo_r;
  assign col  = palette_r[pidx_r];

  always_comb begin
    case (phase_r)
      PH_UP:   bright = ramp;
      PH_HIGH: bright = FULL_BRIGHT;
      PH_DOWN: bright = FULL_BRIGHT - ramp;
      default: bright = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    delta_r <= delta_nxt;
    if (cmd.capture) begin
      now_r   <= in_data.now_ms;
      count_r <= (in_data.pixel_count > MAX_PIXELS) ? MAX_PIXELS : in_data.pixel_count;
    end
    if (cmd.div_load) begin
      rem_r  <= {delta_r, 8'd0} - {8'd0, delta_r};
      den_r  <= {plen_r, 7'd0};
      quo_r  <= 8'd0;
      step_r <= 3'd0;
    end
    if (cmd.div_step) begin
      if (!trial[24]) begin
        rem_r <= trial[23:0];
      end
      quo_r  <= {quo_r[6:0], ~trial[24]};
      den_r  <= {1'b0, den_r[22:1]};
      step_r <= step_r + 3'd1;
    end
    if (cmd.mul) begin
      prod_r[0] <= col[23:16] * bright;
      prod_r[1] <= col[15:8]  * bright;
      prod_r[2] <= col[7:0]   * bright;
    end
    if (cmd.scale) begin
      rgb_r[0] <= div255(prod_r[0]);
      rgb_r[1] <= div255(prod_r[1]);
      rgb_r[2] <= div255(prod_r[2]);
    end
    if (cmd.emit_load) begin
      pix_r <= 6'd0;
    end else if (cmd.emit_next) begin
      pix_r <= pix_r + 6'd1;
    end
  end

  assign sts.div_last = (step_r == 3'd7);
  assign sts.cnt_zero = (count_r == 7'd0);
  assign sts.pix_last = (({1'b0, pix_r} + 7'd1) == count_r);

  assign out_data.pixel_index = pix_r;
  assign out_data.red         = rgb_r[0];
  assign out_data.green       = rgb_r[1];
  assign out_data.blue        = rgb_r[2];
  assign out_data.last_pixel  = sts.pix_last;

endmodule

[rtl/led_breathing_effect.sv]
// ----------------------------------------------------------------------------
// LED breathing effect - top level
// Breathing fade over a small colour palette, one dimmed colour per pixel.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake               Payload
//   in_       input       in_valid / in_ready     in_item_t  (now_ms, pixel_count)
//   out_      output      out_valid / out_ready   out_item_t (pixel_index, red, green,
//                                                             blue, last_pixel)
//   cfg_      input       cfg_we                  cfg_index, cfg_data
//
// A frame request is captured while idle, then passes through initialisation,
// phase update, divider load, the bit-serial ramp divider, channel multiply
// and scaling. It then sends the pixel count, limited to 64, from the output
// register at one pixel per cycle while out_ready is high.
// One request is processed at a time; in_ready is high only while idle.
// Output stalls hold the current pixel and extend the frame while they last.
// Reset is synchronous and restores the configuration and phase state at once;
// there is no clearing pass.
//
// The block moves through ramp up, hold high, ramp down and hold low. Each
// request advances at most one phase; the new phase starts where the old one
// should have ended, so an overrun is carried forward. The palette index steps
// on every return to ramp up. The controller only issues commands; all state
// and arithmetic sit in the datapath.
// ----------------------------------------------------------------------------
module led_breathing_effect
  import lbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  cmd_t cmd;
  sts_t sts;

  // Controller: sequences each transaction through the datapath.
  lbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: configuration, phase state, divider and output register.
  lbe_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

[test/led_breathing_effect_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED breathing effect - testbench
// Drives frame requests through the breathing fade block and checks every
// dimmed pixel against an in-bench model of the phase sequence and palette.
// ----------------------------------------------------------------------------
//
// The run has two parts. A short scripted sequence runs first with the
// register values left at their reset settings. It walks through every phase
// and the first-frame start. It also covers time stepping backwards, the
// wrap of now_ms and the limit on pixel_count. Where a row's colour is
// obvious, such as full brightness of a pure palette colour or black, the
// expected colour is written into the script. Every other row is predicted.
//
// After the script, six register settings follow, each with a burst of
// random frame requests. They include the shortest and longest phases and
// zero-length phases. They also include colour counts that are out of range,
// or lowered while the palette index sits above the new count. Registers are
// only written once the block has drained and sits idle.
//
// Both channels use valid/ready. Every transaction is sampled on the rising
// edge and every input is driven with a nonblocking assignment on that edge.
// The sampled values are therefore the ones that the block saw.
// ----------------------------------------------------------------------------
module led_breathing_effect_tb;
  import lbe_pkg::*;

  localparam int CYCLE_LIMIT       = 1_000_000;
  localparam int ITEMS_PER_SETTING = 74;
  localparam int NUM_SETTINGS      = 6;
  localparam int SCRIPT_ROWS       = 17;
  localparam int DRAIN_CYCLES      = 24;
  localparam int HOLD_OFF_CYCLES   = 400;
  localparam int HOLD_OFF_AFTER    = 400;
  localparam int MAX_REPORTS       = 10;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // One scripted frame request. When has_colour is set, rgb is the dimmed
  // colour that every pixel of the frame must carry.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [6:0]  pixel_count;
    logic        has_colour;
    logic [23:0] rgb;
  } frame_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  // Register values as the block should hold them.
  logic [15:0] ramp_len_cfg     = RAMP_MS_RST;
  logic [15:0] hold_len_cfg     = HOLD_MS_RST;
  logic [2:0]  colour_count_cfg = NUM_COLORS;
  logic [23:0] palette_cfg [4]  = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF};

  // Breathing state, advanced once per accepted frame request.
  logic        eff_started     = 1'b0;
  logic [1:0]  eff_phase       = PH_UP;
  logic [31:0] eff_start_ms    = '0;
  logic [15:0] eff_len_ms      = RAMP_MS_RST;
  logic [1:0]  eff_palette_idx = '0;

  out_item_t   expected_pixels [$];

  int unsigned send_idle_pct  = 38;
  int unsigned recv_idle_pct  = 49;
  int unsigned cycle_count    = 0;
  int unsigned fault_count    = 0;
  int unsigned frames_sent    = 0;
  int unsigned pixels_checked = 0;
  int unsigned phase_changes  = 0;
  int unsigned palette_steps  = 0;

  // With the reset settings (1500 ms ramps, 2000 ms holds, red first), the
  // script starts at 1000 ms and steps through one full cycle. It then moves
  // into green, jumps backwards and across the 32-bit wrap, and ends in blue.
  frame_row_t frame_script [SCRIPT_ROWS] = '{
    '{32'd1000,       7'd1,   1'b1, 24'h000000},  // first frame: ramp up from zero
    '{32'd1750,       7'd3,   1'b0, 24'h000000},  // half way up
    '{32'd2500,       7'd64,  1'b1, 24'hFF0000},  // top of the ramp, full frame
    '{32'd2501,       7'd127, 1'b1, 24'hFF0000},  // into hold high, count limited
    '{32'd4500,       7'd0,   1'b0, 24'h000000},  // empty frame, end of hold
    '{32'd4501,       7'd2,   1'b1, 24'hFF0000},  // ramp down starts at full
    '{32'd5250,       7'd1,   1'b0, 24'h000000},  // half way down
    '{32'd6000,       7'd1,   1'b1, 24'h000000},  // bottom of the ramp
    '{32'd6001,       7'd4,   1'b1, 24'h000000},  // hold low
    '{32'd8001,       7'd1,   1'b1, 24'h000000},  // back to ramp up, green now
    '{32'd9500,       7'd1,   1'b1, 24'h00FF00},  // top of the green ramp
    '{32'd100,        7'd3,   1'b1, 24'h00FF00},  // time goes backwards: hold high
    '{32'hFFFF_FFFF,  7'd65,  1'b1, 24'h00FF00},  // another long delay: ramp down
    '{32'd0,          7'd2,   1'b1, 24'h000000},  // across the wrap: hold low
    '{32'd15001,      7'd1,   1'b1, 24'h000000},  // ramp up, blue now
    '{32'd15751,      7'd1,   1'b0, 24'h000000},  // half way up in blue
    '{32'd16500,      7'd1,   1'b1, 24'h0000FF}   // top of the blue ramp
  };

  led_breathing_effect u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // A stuck handshake or missing pixels end the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("led_breathing_effect_tb failed");
    $finish;
  end

  // Advances the breathing state for one accepted frame request. It returns
  // the dimmed colour of the frame and how many pixels the frame carries.
  function automatic void advance_effect(input in_item_t req, output logic [23:0] dimmed,
                                         output int pixels);
    logic [31:0] elapsed;
    logic [31:0] ramp_val;
    logic [7:0]  level;
    logic [2:0]  wrap_at;
    logic [2:0]  next_idx;
    logic [23:0] colour;
    logic [15:0] r16;
    logic [15:0] g16;
    logic [15:0] b16;

    // The first request after reset opens a ramp up at its own time.
    if (!eff_started) begin
      eff_started  = 1'b1;
      eff_start_ms = req.now_ms;
      eff_len_ms   = ramp_len_cfg;
      eff_phase    = PH_UP;
    end

    // Elapsed time wraps modulo 2^32, so a step backwards reads as a long
    // delay. However long the overrun, only one phase is advanced, and the
    // new phase begins where the old one should have ended.
    elapsed = req.now_ms - eff_start_ms;
    if (elapsed > {16'h0000, eff_len_ms}) begin
      eff_start_ms = eff_start_ms + {16'h0000, eff_len_ms};
      eff_phase    = eff_phase + 2'd1;
      phase_changes++;
      if (eff_phase == PH_HIGH || eff_phase == PH_LOW) begin
        eff_len_ms = hold_len_cfg;
      end else begin
        // A colour count of zero or above the palette size means the whole
        // palette. An index left above a lowered count still picks its own
        // colour, and it wraps to zero on the next step.
        if (eff_phase == PH_UP) begin
          wrap_at  = (colour_count_cfg == 3'd0 || colour_count_cfg > NUM_COLORS) ?
                     NUM_COLORS : colour_count_cfg;
          next_idx = {1'b0, eff_palette_idx} + 3'd1;
          eff_palette_idx = (next_idx >= wrap_at) ? 2'd0 : next_idx[1:0];
          palette_steps++;
        end
        eff_len_ms = ramp_len_cfg;
      end
      elapsed = '0;
    end

    // A zero-length ramp shows its end value at once.
    if (eff_phase == PH_HIGH) begin
      level = FULL_BRIGHT;
    end else if (eff_phase == PH_LOW) begin
      level = 8'd0;
    end else begin
      if (eff_len_ms == 16'd0) begin
        ramp_val = {24'd0, FULL_BRIGHT};
      end else begin
        ramp_val = ({24'd0, FULL_BRIGHT} * elapsed) / {16'h0000, eff_len_ms};
      end
      if (ramp_val > {24'd0, FULL_BRIGHT}) begin
        ramp_val = {24'd0, FULL_BRIGHT};
      end
      level = (eff_phase == PH_UP) ? ramp_val[7:0] : FULL_BRIGHT - ramp_val[7:0];
    end

    colour = palette_cfg[eff_palette_idx];
    r16 = colour[23:16] * level;
    g16 = colour[15:8] * level;
    b16 = colour[7:0] * level;
    r16 = r16 / {8'd0, FULL_BRIGHT};
    g16 = g16 / {8'd0, FULL_BRIGHT};
    b16 = b16 / {8'd0, FULL_BRIGHT};
    dimmed = {r16[7:0], g16[7:0], b16[7:0]};

    pixels = (req.pixel_count > MAX_PIXELS) ? MAX_PIXELS : req.pixel_count;
  endfunction

  // Offers one frame request after a random gap, waits for the transaction,
  // and then queues the pixels that it must produce.
  task automatic offer_frame(input logic [31:0] now, input logic [6:0] count,
                             input logic has_colour, input logic [23:0] rgb);
    in_item_t    req;
    logic [23:0] dimmed;
    int          pixels;
    out_item_t   px;

    req.now_ms      = now;
    req.pixel_count = count;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end

    advance_effect(req, dimmed, pixels);
    if (has_colour) begin
      dimmed = rgb;
    end
    for (int i = 0; i < pixels; i++) begin
      px.pixel_index = i[5:0];
      px.red         = dimmed[23:16];
      px.green       = dimmed[15:8];
      px.blue        = dimmed[7:0];
      px.last_pixel  = (i == pixels - 1);
      expected_pixels.push_back(px);
    end
    frames_sent++;
  endtask

  // Drives a write onto the register port for one edge. The caller drops
  // cfg_we after its last write, so that back-to-back writes leave the
  // enable high throughout.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_RAMP_MS:     ramp_len_cfg     = val[15:0];
      REG_HOLD_MS:     hold_len_cfg     = val[15:0];
      REG_COLOR_COUNT: colour_count_cfg = val[2:0];
      REG_COLOR_0:     palette_cfg[0]   = val;
      REG_COLOR_1:     palette_cfg[1]   = val;
      REG_COLOR_2:     palette_cfg[2]   = val;
      REG_COLOR_3:     palette_cfg[3]   = val;
      default:         ;
    endcase
  endtask

  // Loads one of the register settings. The bits above each register's
  // width are filled at random, and they must be ignored.
  task automatic apply_setting(input int k);
    logic [15:0] ramp;
    logic [15:0] hold;
    logic [2:0]  colours;
    logic [23:0] pal [4];

    foreach (pal[i]) pal[i] = $urandom_range(0, 24'hFF_FFFF);
    case (k)
      0: begin ramp = 16'd20;    hold = 16'd10;    colours = 3'd4; end
      1: begin
        // Shortest phases and a count of zero, with black and white in the palette.
        ramp = 16'd1; hold = 16'd1; colours = 3'd0;
        pal[0] = 24'h000000; pal[1] = 24'hFFFFFF; pal[3] = 24'hFFFFFF;
      end
      2: begin ramp = 16'hFFFF;  hold = 16'hFFFF;  colours = 3'd7; end
      3: begin ramp = 16'd0;     hold = 16'd0;     colours = 3'd2; end
      4: begin ramp = 16'd7;     hold = 16'd3;     colours = 3'd3; end
      default: begin
        ramp = 16'd5; hold = 16'd9; colours = 3'd1;
        pal[0] = 24'hFFFFFF; pal[1] = 24'h000000;
      end
    endcase
    write_reg(REG_RAMP_MS, {8'($urandom_range(0, 255)), ramp});
    write_reg(REG_HOLD_MS, {8'($urandom_range(0, 255)), hold});
    write_reg(REG_COLOR_COUNT, {21'($urandom_range(0, 21'h1F_FFFF)), colours});
    write_reg(REG_COLOR_0, pal[0]);
    write_reg(REG_COLOR_1, pal[1]);
    write_reg(REG_COLOR_2, pal[2]);
    write_reg(REG_COLOR_3, pal[3]);
    write_reg(REG_UNUSED, 24'($urandom_range(0, 24'hFF_FFFF)));
    cfg_we <= 1'b0;
  endtask

  // Waits until every expected pixel has arrived. A frame of zero pixels may
  // still be running after that, so the block is given time to finish it.
  task automatic drain();
    while (expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: checks each pixel transaction and decides out_ready for the
  // next edge. Once, after some traffic, the receiver holds off for a long
  // stretch. The sender carries on offering, so that the block fills up and
  // drops in_ready.
  initial begin
    out_item_t   want;
    int unsigned hold_off;
    logic        hold_off_done;

    hold_off      = 0;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("Pixel with nothing expected: idx %0d rgb %h%h%h last %0b",
                     out_data.pixel_index, out_data.red, out_data.green,
                     out_data.blue, out_data.last_pixel);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.pixel_index !== want.pixel_index || out_data.red !== want.red ||
              out_data.green !== want.green || out_data.blue !== want.blue ||
              out_data.last_pixel !== want.last_pixel) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("Pixel mismatch: expected %0d %h%h%h %0b, got %0d %h%h%h %0b",
                       want.pixel_index, want.red, want.green, want.blue,
                       want.last_pixel, out_data.pixel_index, out_data.red,
                       out_data.green, out_data.blue, out_data.last_pixel);
            end
          end
          pixels_checked++;
        end
      end

      if (!hold_off_done && pixels_checked >= HOLD_OFF_AFTER) begin
        hold_off      = HOLD_OFF_CYCLES;
        hold_off_done = 1'b1;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Request side: reset, the scripted walk, then random bursts per setting.
  initial begin
    logic [31:0] frame_now;
    logic [31:0] span;
    logic [6:0]  count;
    int unsigned sel;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      offer_frame(frame_script[r].now_ms, frame_script[r].pixel_count,
                  frame_script[r].has_colour, frame_script[r].rgb);
    end
    in_valid  <= 1'b0;
    frame_now = frame_script[SCRIPT_ROWS - 1].now_ms;

    for (int k = 0; k < NUM_SETTINGS; k++) begin
      drain();
      apply_setting(k);
      // Two settings with the sender idling less than the receiver, two the
      // other way round, and the last two with both sides flat out.
      case (k / 2)
        0:       begin send_idle_pct = 38; recv_idle_pct = 49; end
        1:       begin send_idle_pct = 49; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase

      for (int j = 0; j < ITEMS_PER_SETTING; j++) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          // Ordinary progress, a fraction of a phase at a time.
          span      = $urandom_range(0, (32'(ramp_len_cfg) + 32'(hold_len_cfg)) / 2 + 1);
          frame_now = frame_now + span;
        end else if (sel < 8) begin
          // Land exactly on the end of the current phase or one past it.
          span      = 32'(eff_len_ms) + 32'($urandom_range(0, 1));
          frame_now = eff_start_ms + span;
        end else if (sel == 8) begin
          // Jump anywhere, possibly backwards.
          frame_now = $urandom();
        end else begin
          // Small step backwards.
          span      = $urandom_range(1, 1000);
          frame_now = frame_now - span;
        end
        if ($urandom_range(0, 3) == 0) begin
          count = 7'($urandom_range(65, 127));
        end else begin
          count = 7'($urandom_range(0, 64));
        end
        offer_frame(frame_now, count, 1'b0, 24'h000000);
      end
      in_valid <= 1'b0;
    end

    drain();
    $display("Run covered %0d frame requests and %0d pixels over the script and %0d settings,",
             frames_sent, pixels_checked, NUM_SETTINGS);
    $display("with %0d phase changes, %0d palette steps and one long receiver stall.",
             phase_changes, palette_steps);
    if (fault_count == 0) begin
      $display("led_breathing_effect_tb passed");
    end else begin
      $display("led_breathing_effect_tb failed");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/lbe_pkg.sv
rtl/lbe_ctrl.sv
rtl/lbe_dpath.sv
rtl/led_breathing_effect.sv
test/led_breathing_effect_tb.sv
